[hdl/poc_pkg.sv]
// ----------------------------------------------------------------------------
// poc_pkg
// shared types and constants of the pattern occurrence counter
// ----------------------------------------------------------------------------
package poc_pkg;

  // default sizes
  localparam int                MAX_PATTERN_DEF = 16;
  localparam longint unsigned   MAX_TEXT_DEF    = 64'd65536;
  localparam int                QUEUE_DEPTH_DEF = 4;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int POS_W   = 16;
  localparam int CNT_W   = 17;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 5;

  // register index codes, taken from paddr[4:3]
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  // classified byte handed from front to back
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] start;
    logic             last;
  } poc_item_t;

endpackage

[hdl/poc_front.sv]
// ----------------------------------------------------------------------------
// poc_front
// byte window, position tracking and parallel pattern compare
// ----------------------------------------------------------------------------
module poc_front #(
  parameter int              MAX_PATTERN = poc_pkg::MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT    = poc_pkg::MAX_TEXT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [poc_pkg::BYTE_W-1:0]  text_byte,
  input  logic                        end_of_text,
  input  logic [poc_pkg::CFG_W-1:0]   pat_low,
  input  logic [poc_pkg::CFG_W-1:0]   pat_high,
  input  logic [poc_pkg::LEN_W-1:0]   pat_len,
  output poc_pkg::poc_item_t          item
);

  localparam logic [poc_pkg::POS_W-1:0] POS_CAP =
    (MAX_TEXT - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(MAX_TEXT - 64'd1);

  logic [poc_pkg::BYTE_W-1:0] win_r   [MAX_PATTERN];
  logic [poc_pkg::BYTE_W-1:0] win_nxt [MAX_PATTERN];
  logic [poc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [MAX_PATTERN-1:0]     lane_ok;
  logic                       len_ok, enough;
  logic [poc_pkg::POS_W:0]    pos_plus1;

  function automatic logic [poc_pkg::BYTE_W-1:0] pat_byte(
    input logic [poc_pkg::CFG_W-1:0] lo,
    input logic [poc_pkg::CFG_W-1:0] hi,
    input logic [5:0]                k
  );
    logic [poc_pkg::BYTE_W-1:0] b;
    b = '0;
    if (k < 6'd8) begin
      b = lo[k[2:0]*8 +: 8];
    end else if (k < 6'd16) begin
      b = hi[k[2:0]*8 +: 8];
    end
    return b;
  endfunction

  // shifted window, newest byte in lane 0
  always_comb begin
    win_nxt[0] = text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // lanes past the pattern length always pass
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (j >= int'(pat_len)) begin
        lane_ok[j] = 1'b1;
      end else begin
        lane_ok[j] = (win_nxt[j] ==
          pat_byte(pat_low, pat_high, 6'(pat_len) - 6'd1 - 6'(j)));
      end
    end
  end

  assign len_ok    = (pat_len != '0) && (int'(pat_len) <= MAX_PATTERN);
  assign pos_plus1 = {1'b0, pos_r} + 17'd1;
  assign enough    = pos_plus1 >= 17'(pat_len);

  always_comb begin
    item.hit   = len_ok && enough && (&lane_ok);
    item.start = item.hit ? 16'(pos_plus1 - 17'(pat_len)) : '0;
    item.last  = end_of_text;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (end_of_text) begin
      pos_nxt = '0;
    end else if (pos_r < POS_CAP) begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

[hdl/poc_queue.sv]
// ----------------------------------------------------------------------------
// poc_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module poc_queue #(
  parameter int DEPTH = poc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  poc_pkg::poc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output poc_pkg::poc_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  poc_pkg::poc_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hdl/poc_back.sv]
// ----------------------------------------------------------------------------
// poc_back
// running match count and registered result stage
// ----------------------------------------------------------------------------
module poc_back #(
  parameter longint unsigned MAX_TEXT = poc_pkg::MAX_TEXT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  poc_pkg::poc_item_t         q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [poc_pkg::POS_W-1:0]  out_start,
  output logic [poc_pkg::CNT_W-1:0]  out_count,
  output logic                       out_last
);

  localparam logic [poc_pkg::CNT_W-1:0] CNT_CAP =
    (MAX_TEXT > 64'd65536) ? 17'h10000 : 17'(MAX_TEXT);

  logic                      vld_r, vld_nxt;
  logic [poc_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  poc_pkg::poc_item_t        res_item_r;
  logic [poc_pkg::CNT_W-1:0] res_cnt_r;

  assign q_pop   = q_valid && (!vld_r || out_ready);
  assign cnt_upd = (q_item.hit && (cnt_r < CNT_CAP)) ? cnt_r + 17'd1 : cnt_r;

  always_comb begin
    vld_nxt = vld_r && !out_ready;
    cnt_nxt = cnt_r;
    if (q_pop) begin
      vld_nxt = 1'b1;
      cnt_nxt = q_item.last ? '0 : cnt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_item_r <= q_item;
      res_cnt_r  <= cnt_upd;
    end
  end

  assign out_valid = vld_r;
  assign out_hit   = res_item_r.hit;
  assign out_start = res_item_r.start;
  assign out_count = res_cnt_r;
  assign out_last  = res_item_r.last;

endmodule

[hdl/pattern_occurrence_counter_unit.sv]
// ----------------------------------------------------------------------------
// pattern_occurrence_counter_unit
// counts exact, overlapping occurrences of a pattern of up to 16 bytes
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in_     | slave     | in_tvalid / in_tready   | text byte, end of text (tlast)
//  out_    | master    | out_tvalid / out_tready | start index, count, match
//          |           |                         | (tuser), last byte (tlast)
//  cfg_    | apb slave | psel / penable, pready  | pattern low, high, length
//
//  one request per clock while the queue has room; a byte's result is written
//  into the queue, then into the result register
//  the compare of all window lanes against the pattern is done in parallel in
//  the cycle a byte is taken, so no loop limits the rate
//  a four-entry queue sits between front and back, so in_tready only drops
//  after the result side has stalled long enough to fill it
//  rst_n is synchronous and active low; it clears position, count, queue and
//  the result valid; pattern registers return to zero, length to one
//
// ----------------------------------------------------------------------------
module pattern_occurrence_counter_unit #(
  parameter int              MAX_PATTERN = poc_pkg::MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT    = poc_pkg::MAX_TEXT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,    // [7:0] text_byte
  input  logic                        in_tlast,    // end_of_text
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,   // [15:0] start_index,
                                                   // [32:16] match_count, rest 0
  output logic                        out_tuser,   // match_found
  output logic                        out_tlast,   // last_byte
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [poc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [poc_pkg::CFG_W-1:0]   cfg_pwdata,
  output logic [poc_pkg::CFG_W-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  // configuration registers
  logic [poc_pkg::CFG_W-1:0] pat_low_r, pat_high_r;
  logic [poc_pkg::LEN_W-1:0] pat_len_r;
  logic                      cfg_wr;

  // front to queue, queue to back
  logic                      in_acc;
  logic                      q_full, q_valid, q_pop;
  poc_pkg::poc_item_t        front_item, q_item;

  // result fields
  logic                      res_hit, res_last;
  logic [poc_pkg::POS_W-1:0] res_start;
  logic [poc_pkg::CNT_W-1:0] res_count;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // registers sit at 8-byte steps, so paddr[4:3] picks the register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= poc_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        poc_pkg::REG_PAT_LOW:  pat_low_r  <= cfg_pwdata;
        poc_pkg::REG_PAT_HIGH: pat_high_r <= cfg_pwdata;
        poc_pkg::REG_PAT_LEN:  pat_len_r  <= cfg_pwdata[poc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      poc_pkg::REG_PAT_LOW:  cfg_prdata = pat_low_r;
      poc_pkg::REG_PAT_HIGH: cfg_prdata = pat_high_r;
      poc_pkg::REG_PAT_LEN:  cfg_prdata = {{(poc_pkg::CFG_W-poc_pkg::LEN_W){1'b0}}, pat_len_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- front
  // take a byte whenever the queue has room
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  poc_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .pat_low     (pat_low_r),
    .pat_high    (pat_high_r),
    .pat_len     (pat_len_r),
    .item        (front_item)
  );

  // ---------------------------------------------------------------- queue
  poc_queue #(
    .DEPTH (poc_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  // ---------------------------------------------------------------- back
  poc_back #(
    .MAX_TEXT (MAX_TEXT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hit   (res_hit),
    .out_start (res_start),
    .out_count (res_count),
    .out_last  (res_last)
  );

  // pack result, upper pad bits stay zero
  assign out_tdata = {7'd0, res_count, res_start};
  assign out_tuser = res_hit;
  assign out_tlast = res_last;

endmodule

[hdl/poc_checker.sv]
// ----------------------------------------------------------------------------
// poc_checker
// port-level checks of the pattern occurrence counter
// ----------------------------------------------------------------------------
module poc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [4:0]  cfg_paddr,
  input logic [63:0] cfg_pwdata,
  input logic [63:0] cfg_prdata,
  input logic        cfg_pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // no match means start index reads zero
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[15:0] == 16'd0)
    else $error("start index set without a match");

  // a match leaves a nonzero count
  a_count_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[32:16] != 17'd0)
    else $error("match reported with zero count");

  // count saturates, padding stays clear
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32:16] <= 17'h10000 && out_tdata[39:33] == 7'd0)
    else $error("count beyond saturation or pad bits set");

endmodule

bind pattern_occurrence_counter_unit poc_checker u_poc_checker (.*);
